// ----- src/tmcb_pkg.sv -----
// shared types and codes of the text mode character buffer
package tmcb_pkg;

	localparam logic [2:0] CMD_PUT_CHAR   = 3'd0;
	localparam logic [2:0] CMD_WRITE_AT   = 3'd1;
	localparam logic [2:0] CMD_SET_CURSOR = 3'd2;
	localparam logic [2:0] CMD_FILL_ALL   = 3'd3;
	localparam logic [2:0] CMD_FILL_RECT  = 3'd4;
	localparam logic [2:0] CMD_READ_CELL  = 3'd5;

	localparam logic [7:0] CODE_NEWLINE = 8'd10;
	localparam logic [7:0] CODE_NUL     = 8'd0;

	localparam logic REG_SCREEN_COLUMNS = 1'b0;
	localparam logic REG_SCREEN_ROWS    = 1'b1;

	localparam logic [7:0] COLUMNS_RESET = 8'd80;
	localparam logic [7:0] ROWS_RESET    = 8'd25;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] char_code;
		logic [7:0] column;
		logic [7:0] row;
		logic       keep_column;
		logic       keep_row;
		logic [7:0] rect_width;
		logic [7:0] rect_height;
	} cmd_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [7:0] cursor_column;
		logic [7:0] cursor_row;
		logic       out_of_range;
	} rsp_t;

endpackage

// ----- src/tmcb_ram.sv -----
// generic single port ram with registered read
module tmcb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ----- src/text_mode_character_buffer.sv -----
// Character cell store of a text mode display with cursor. After reset the block runs a
// clearing pass over the cell memory with cmd_stall high; configuration writes are taken
// during it. Commands are then handled one at a time by a sequencer around one single port
// memory with registered read. fill_all writes min(screen_columns * screen_rows,
// MAX_CELLS) cells and fill_rect walks rect_width * rect_height cells, one memory write
// per cell on the screen. A new command is taken while the previous result waits on
// rsp_stall.
module text_mode_character_buffer #(
	parameter int MAX_CELLS = 4096
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  tmcb_pkg::cmd_t cmd,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output tmcb_pkg::rsp_t rsp,
	input  logic           cfg_we,
	input  logic           cfg_index,
	input  logic [7:0]     cfg_data
);

	localparam int AW = $clog2(MAX_CELLS);
	localparam int CW = $clog2(MAX_CELLS + 1);
	localparam logic [17:0]   MAX_IDX = 18'(MAX_CELLS);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_CELLS);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_LOAD  = 3'd2;
	localparam logic [2:0] S_EXEC  = 3'd3;
	localparam logic [2:0] S_FILL  = 3'd4;
	localparam logic [2:0] S_RECT  = 3'd5;
	localparam logic [2:0] S_READ  = 3'd6;
	localparam logic [2:0] S_RESP  = 3'd7;

	logic [2:0]     state_q;
	logic [CW-1:0]  cnt_q;
	logic [7:0]     cols_q;
	logic [7:0]     rows_q;
	logic [7:0]     cur_col_q;
	logic [7:0]     cur_row_q;
	logic           rsp_valid_q;
	tmcb_pkg::cmd_t req_q;
	tmcb_pkg::rsp_t rsp_q;
	logic           flag_q;
	logic [7:0]     rd_q;
	logic [15:0]    prod_q;
	logic [CW-1:0]  lim_q;
	logic [8:0]     x_q;
	logic [8:0]     y_q;
	logic [16:0]    base_q;

	logic           take_c;
	logic           take_r;
	logic           c_ok;
	logic           r_ok;
	logic [7:0]     new_col;
	logic [7:0]     new_row;
	logic           load_bad;
	logic [7:0]     mul_a;
	logic [15:0]    prod;
	logic [7:0]     col_sel;
	logic [7:0]     row_sel;
	logic [17:0]    cell_idx;
	logic           cell_on;
	logic [7:0]     row_down;
	logic           col_wrap;
	logic           is_char;
	logic [17:0]    rect_idx;
	logic           rect_on;
	logic [8:0]     x_end;
	logic [8:0]     y_end;
	logic           x_last;
	logic           y_last;
	logic           rsp_free;
	logic           ram_we;
	logic [AW-1:0]  ram_addr;
	logic [7:0]     ram_wdata;
	logic [7:0]     ram_rdata;

	assign cmd_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	// cursor load and row times columns product
	always_comb begin
		take_c = (req_q.command == tmcb_pkg::CMD_SET_CURSOR)
			|| (((req_q.command == tmcb_pkg::CMD_PUT_CHAR)
			|| (req_q.command == tmcb_pkg::CMD_WRITE_AT)) && !req_q.keep_column);
		take_r = (req_q.command == tmcb_pkg::CMD_SET_CURSOR)
			|| (((req_q.command == tmcb_pkg::CMD_PUT_CHAR)
			|| (req_q.command == tmcb_pkg::CMD_WRITE_AT)) && !req_q.keep_row);
		c_ok     = req_q.column < cols_q;
		r_ok     = req_q.row < rows_q;
		new_col  = (take_c && c_ok) ? req_q.column : cur_col_q;
		new_row  = (take_r && r_ok) ? req_q.row : cur_row_q;
		load_bad = (take_c && !c_ok) || (take_r && !r_ok);
		if (req_q.command == tmcb_pkg::CMD_FILL_ALL) begin
			mul_a = rows_q;
		end else if ((req_q.command == tmcb_pkg::CMD_FILL_RECT)
			|| (req_q.command == tmcb_pkg::CMD_READ_CELL)) begin
			mul_a = req_q.row;
		end else begin
			mul_a = new_row;
		end
		prod = 16'(mul_a) * 16'(cols_q);
	end

	// single cell access and cursor advance
	always_comb begin
		col_sel  = (req_q.command == tmcb_pkg::CMD_READ_CELL) ? req_q.column : cur_col_q;
		row_sel  = (req_q.command == tmcb_pkg::CMD_READ_CELL) ? req_q.row : cur_row_q;
		cell_idx = 18'(col_sel) + 18'(prod_q);
		cell_on  = (col_sel < cols_q) && (row_sel < rows_q) && (cell_idx < MAX_IDX);
		row_down = ((9'(cur_row_q) + 9'd1) < 9'(rows_q)) ? (cur_row_q + 8'd1) : cur_row_q;
		col_wrap = (9'(cur_col_q) + 9'd1) >= 9'(cols_q);
		is_char  = (req_q.char_code != tmcb_pkg::CODE_NEWLINE)
			&& (req_q.char_code != tmcb_pkg::CODE_NUL);
	end

	// rectangle walk
	always_comb begin
		rect_idx = 18'(x_q) + 18'(base_q);
		rect_on  = (x_q < 9'(cols_q)) && (y_q < 9'(rows_q)) && (rect_idx < MAX_IDX);
		x_end    = 9'(req_q.column) + 9'(req_q.rect_width);
		y_end    = 9'(req_q.row) + 9'(req_q.rect_height);
		x_last   = (x_q + 9'd1) == x_end;
		y_last   = (y_q + 9'd1) == y_end;
	end

	// memory port
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = cell_idx[AW-1:0];
		ram_wdata = req_q.char_code;
		case (state_q)
			S_CLEAR: begin
				ram_we    = (cnt_q != MAX_CNT);
				ram_addr  = cnt_q[AW-1:0];
				ram_wdata = tmcb_pkg::CODE_NUL;
			end
			S_EXEC: begin
				ram_we = cell_on && (((req_q.command == tmcb_pkg::CMD_PUT_CHAR) && is_char)
					|| (req_q.command == tmcb_pkg::CMD_WRITE_AT));
			end
			S_FILL: begin
				ram_we   = (cnt_q != lim_q);
				ram_addr = cnt_q[AW-1:0];
			end
			S_RECT: begin
				ram_we   = rect_on;
				ram_addr = rect_idx[AW-1:0];
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	tmcb_ram #(
		.WIDTH (8),
		.DEPTH (MAX_CELLS)
	) u_cells (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			cnt_q       <= '0;
			cols_q      <= tmcb_pkg::COLUMNS_RESET;
			rows_q      <= tmcb_pkg::ROWS_RESET;
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == tmcb_pkg::REG_SCREEN_COLUMNS) begin
					cols_q <= cfg_data;
				end else begin
					rows_q <= cfg_data;
				end
			end
			if ((state_q == S_RESP) && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					if (cnt_q == MAX_CNT) begin
						state_q <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				S_IDLE: begin
					if (cmd_valid) begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					cur_col_q <= new_col;
					cur_row_q <= new_row;
					state_q   <= S_EXEC;
				end
				S_EXEC: begin
					case (req_q.command)
						tmcb_pkg::CMD_PUT_CHAR: begin
							if (req_q.char_code == tmcb_pkg::CODE_NEWLINE) begin
								cur_col_q <= '0;
								cur_row_q <= row_down;
							end else if (is_char && cell_on) begin
								if (col_wrap) begin
									cur_col_q <= '0;
									cur_row_q <= row_down;
								end else begin
									cur_col_q <= cur_col_q + 8'd1;
								end
							end
							state_q <= S_RESP;
						end
						tmcb_pkg::CMD_FILL_ALL: begin
							cnt_q   <= '0;
							state_q <= S_FILL;
						end
						tmcb_pkg::CMD_FILL_RECT: begin
							if ((req_q.rect_width == 8'd0) || (req_q.rect_height == 8'd0)) begin
								state_q <= S_RESP;
							end else begin
								state_q <= S_RECT;
							end
						end
						tmcb_pkg::CMD_READ_CELL: begin
							state_q <= cell_on ? S_READ : S_RESP;
						end
						default: begin
							state_q <= S_RESP;
						end
					endcase
				end
				S_FILL: begin
					if (cnt_q == lim_q) begin
						state_q <= S_RESP;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				S_RECT: begin
					if (x_last && y_last) begin
						state_q <= S_RESP;
					end
				end
				S_READ: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					req_q <= cmd;
				end
			end
			S_LOAD: begin
				flag_q <= load_bad;
				rd_q   <= '0;
				prod_q <= prod;
			end
			S_EXEC: begin
				case (req_q.command)
					tmcb_pkg::CMD_PUT_CHAR: begin
						if (is_char && !cell_on) begin
							flag_q <= 1'b1;
						end
					end
					tmcb_pkg::CMD_WRITE_AT,
					tmcb_pkg::CMD_READ_CELL: begin
						if (!cell_on) begin
							flag_q <= 1'b1;
						end
					end
					tmcb_pkg::CMD_FILL_ALL: begin
						if (18'(prod_q) > MAX_IDX) begin
							lim_q  <= MAX_CNT;
							flag_q <= 1'b1;
						end else begin
							lim_q <= CW'(prod_q);
						end
					end
					tmcb_pkg::CMD_FILL_RECT: begin
						x_q    <= 9'(req_q.column);
						y_q    <= 9'(req_q.row);
						base_q <= 17'(prod_q);
					end
					default: begin
						flag_q <= flag_q;
					end
				endcase
			end
			S_RECT: begin
				if (!rect_on) begin
					flag_q <= 1'b1;
				end
				if (x_last) begin
					x_q    <= 9'(req_q.column);
					y_q    <= y_q + 9'd1;
					base_q <= base_q + 17'(cols_q);
				end else begin
					x_q <= x_q + 9'd1;
				end
			end
			S_READ: begin
				rd_q <= ram_rdata;
			end
			S_RESP: begin
				if (rsp_free) begin
					rsp_q.read_data     <= rd_q;
					rsp_q.cursor_column <= cur_col_q;
					rsp_q.cursor_row    <= cur_row_q;
					rsp_q.out_of_range  <= flag_q;
				end
			end
			default: begin
				rd_q <= rd_q;
			end
		endcase
	end

	a_accept_starts_load: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) |=> (state_q == S_LOAD))
		else $error("accepted command did not start the sequencer");

	a_no_write_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_RESP || state_q == S_READ) |-> !ram_we)
		else $error("cell write outside a command");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FILL) |-> (cnt_q <= lim_q))
		else $error("fill ran past its limit");

	a_result_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(state_q) == S_RESP))
		else $error("result raised outside the response state");

	a_clear_done_before_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (cnt_q == MAX_CNT || $past(state_q) != S_CLEAR))
		else $error("clearing pass left early");

endmodule
